/* hw/rtl/gsu_pkg.sv */
// ----------------------------------------------------------------------------
// gsu_pkg: shared constants for the upper-opcode execute block
// Opcode group boundaries and default sizes of the banked data RAM.
// ----------------------------------------------------------------------------
`default_nettype none
package gsu_pkg;
  localparam int GSU_RAM_BANKS     = 2;
  localparam int GSU_RAM_ADDR_BITS = 16;

  localparam logic [3:0] GRP_IBT  = 4'hA;
  localparam logic [3:0] GRP_FROM = 4'hB;
  localparam logic [3:0] GRP_C    = 4'hC;
  localparam logic [3:0] GRP_D    = 4'hD;
  localparam logic [3:0] GRP_E    = 4'hE;
  localparam logic [3:0] GRP_IWT  = 4'hF;
endpackage
`default_nettype wire

/* hw/rtl/gsu_byte_ram.sv */
// ----------------------------------------------------------------------------
// gsu_byte_ram: banked byte RAM as two byte lanes (even and odd address)
// One 16-bit word access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gsu_byte_ram
  import gsu_pkg::*;
#(
  parameter int AW = 17
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata_even,
  input  wire logic [7:0]    wdata_odd,
  output logic      [7:0]    rdata_even,
  output logic      [7:0]    rdata_odd
);
  localparam int DEPTH = 1 << AW;
  logic [7:0] mem_even [DEPTH];
  logic [7:0] mem_odd  [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_even[waddr] <= wdata_even;
        mem_odd[waddr]  <= wdata_odd;
      end
      rdata_even <= mem_even[waddr];
      rdata_odd  <= mem_odd[waddr];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/gsu_upper_opcode_execute.sv */
// ----------------------------------------------------------------------------
// gsu_upper_opcode_execute: executes opcodes A0-FF of a 16-register coprocessor
//
// Usage: present one instruction beat on the in_ channel (opcode, ALT1/ALT2/
// WITH prefixes, source/destination selects, immediates, ROM buffer byte).
// One result beat per instruction leaves on the out_ channel with the written
// register, flags, RAM address, bank selects and prefix status.
// The accepting edge loads stage 2 (decode, register file read, RAM word
// access issued); when stage 2 advances, it takes RAM read data, writes
// the register file and flags, and loads the output register (out_valid).
// Throughput: one instruction per cycle while the receiver does not stall;
// the RAM port and register write-back are pipelined, and stage 2 results
// forward into stage 1 operand reads.
// A 16-bit RAM word sits in an even and an odd byte lane; LM/SM with an odd
// address swap lanes, so a word is always one lane access.
// Reset clears registers, flags, bank selects, address register and valids;
// RAM content stays undefined until written. When the receiver stalls, the
// output register holds and in_ready drops once stage 2 is blocked.
// ----------------------------------------------------------------------------
`default_nettype none
module gsu_upper_opcode_execute
  import gsu_pkg::*;
#(
  parameter int RAM_BANKS     = GSU_RAM_BANKS,
  parameter int RAM_ADDR_BITS = GSU_RAM_ADDR_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_opcode,
  input  wire logic        in_alt1,
  input  wire logic        in_alt2,
  input  wire logic        in_with_prefix,
  input  wire logic [3:0]  in_src_sel,
  input  wire logic [3:0]  in_dst_sel,
  input  wire logic [7:0]  in_imm_low,
  input  wire logic [7:0]  in_imm_high,
  input  wire logic [7:0]  in_rom_buffer_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_wrote_register,
  output logic [3:0]       out_written_index,
  output logic [15:0]      out_written_value,
  output logic             out_zero_flag,
  output logic             out_sign_flag,
  output logic             out_overflow_flag,
  output logic [15:0]      out_last_ram_address,
  output logic             out_ram_bank_out,
  output logic [6:0]       out_rom_bank_out,
  output logic [3:0]       out_next_src_sel,
  output logic             out_prefix_cleared,
  output logic [1:0]       out_operand_bytes_used
);
  localparam int BW = (RAM_BANKS > 1) ? 1 : 0;
  localparam int WA = RAM_ADDR_BITS - 1;   // word address bits
  localparam int AW = WA + 1;              // plus bank bit (kept even at 1 bank)

  // architectural state
  logic [15:0] rf_r [16];
  logic        zf_r, sf_r, of_r, rbank_r;
  logic [6:0]  rombank_r;
  logic [15:0] ramaddr_r;

  // stage 2 (after RAM access)
  logic        s2_valid_r, s2_load_r, s2_swap_r, s2_wr_r;
  logic [3:0]  s2_widx_r;
  logic [15:0] s2_wval_r;
  logic        s2_setzs_r, s2_hib_r, s2_setov_r;
  logic [3:0]  s2_nsrc_r;
  logic        s2_clr_r;
  logic [1:0]  s2_used_r;
  logic [15:0] s2_addr_r;
  logic        s2_rbank_r;
  logic [6:0]  s2_rombank_r;

  logic        s2_go, s1_go;
  logic [7:0]  ram_re, ram_ro;
  logic [15:0] s2_val;

  assign s2_go    = s2_valid_r && (!out_valid || out_ready);
  assign in_ready = !s2_valid_r || s2_go;
  assign s1_go    = in_valid && in_ready;

  // stage 2 value: RAM word for loads, else computed value
  always_comb begin
    if (s2_load_r) begin
      s2_val = s2_swap_r ? {ram_re, ram_ro} : {ram_ro, ram_re};
    end else begin
      s2_val = s2_wval_r;
    end
  end

  // forwarded register read: a pending stage 2 write is not yet in rf_r
  function automatic logic [15:0] rd(input logic [3:0] i, input logic [15:0] fv,
                                     input logic fw, input logic [3:0] fi,
                                     input logic [15:0] rv);
    rd = (fw && fi == i) ? fv : rv;
  endfunction

  logic [3:0]  grp, n;
  logic [15:0] s_v, n_v, w_nxt, lmaddr, lwaddr;
  logic        fwd, wr_nxt, load_nxt, store_nxt, swap_nxt;
  logic        setzs_nxt, hib_nxt, setov_nxt, clr_nxt;
  logic [3:0]  widx_nxt, nsrc_nxt;
  logic [1:0]  used_nxt;
  logic        addr_upd;
  logic        rbank_nxt;
  logic [6:0]  rombank_nxt;
  logic [WA-1:0] word_a;
  logic [AW-1:0] ram_a;

  assign grp = in_opcode[7:4];
  assign n   = in_opcode[3:0];
  assign fwd = s2_valid_r && s2_wr_r;
  assign s_v = rd(in_src_sel, s2_val, fwd, s2_widx_r, rf_r[in_src_sel]);
  assign n_v = rd(n, s2_val, fwd, s2_widx_r, rf_r[n]);

  // decode
  always_comb begin
    wr_nxt = 1'b0; widx_nxt = 4'd0; w_nxt = 16'd0;
    load_nxt = 1'b0; store_nxt = 1'b0; swap_nxt = 1'b0;
    setzs_nxt = 1'b0; hib_nxt = 1'b0; setov_nxt = 1'b0;
    nsrc_nxt = 4'd0; clr_nxt = 1'b1; used_nxt = 2'd0;
    addr_upd = 1'b0; lwaddr = 16'd0;
    rbank_nxt = rbank_r; rombank_nxt = rombank_r;
    lmaddr = {in_imm_high, in_imm_low};
    unique case (grp)
      GRP_IBT: begin
        used_nxt = 2'd1;
        lwaddr = {7'd0, in_imm_low, 1'b0};
        if (in_alt1) begin
          addr_upd = 1'b1; load_nxt = 1'b1; wr_nxt = 1'b1; widx_nxt = n;
        end else if (in_alt2) begin
          addr_upd = 1'b1; store_nxt = 1'b1; w_nxt = n_v;
        end else begin
          wr_nxt = 1'b1; widx_nxt = n;
          w_nxt = {{8{in_imm_low[7]}}, in_imm_low};
        end
      end
      GRP_FROM: begin
        if (in_with_prefix) begin
          wr_nxt = 1'b1; widx_nxt = in_dst_sel; w_nxt = n_v;
          setov_nxt = 1'b1; setzs_nxt = 1'b1;
        end else begin
          nsrc_nxt = n; clr_nxt = 1'b0;
        end
      end
      GRP_C: begin
        wr_nxt = 1'b1; widx_nxt = in_dst_sel;
        if (n == 4'd0) begin
          w_nxt = {8'd0, s_v[15:8]}; hib_nxt = 1'b1;
        end else begin
          setzs_nxt = 1'b1;
          w_nxt = in_alt1 ? (s_v ^ (in_alt2 ? {12'd0, n} : n_v))
                          : (s_v | (in_alt2 ? {12'd0, n} : n_v));
        end
      end
      GRP_D: begin
        if (n == 4'hF) begin
          if (in_alt2) begin
            if (in_alt1) rombank_nxt = s_v[6:0];
            else         rbank_nxt = s_v[0];
          end
        end else begin
          wr_nxt = 1'b1; widx_nxt = n; w_nxt = n_v + 16'd1; setzs_nxt = 1'b1;
        end
      end
      GRP_E: begin
        wr_nxt = 1'b1;
        if (n == 4'hF) begin
          widx_nxt = in_dst_sel;
          if (in_alt1 && in_alt2) w_nxt = {{8{in_rom_buffer_byte[7]}}, in_rom_buffer_byte};
          else if (in_alt2)       w_nxt = {s_v[15:8], in_rom_buffer_byte};
          else if (in_alt1)       w_nxt = {in_rom_buffer_byte, s_v[7:0]};
          else                    w_nxt = {8'd0, in_rom_buffer_byte};
        end else begin
          widx_nxt = n; w_nxt = n_v - 16'd1; setzs_nxt = 1'b1;
        end
      end
      GRP_IWT: begin
        used_nxt = 2'd2;
        lwaddr = lmaddr; swap_nxt = in_imm_low[0];
        if (in_alt1) begin
          addr_upd = 1'b1; load_nxt = 1'b1; wr_nxt = 1'b1; widx_nxt = n;
        end else if (in_alt2) begin
          addr_upd = 1'b1; store_nxt = 1'b1; w_nxt = n_v;
        end else begin
          wr_nxt = 1'b1; widx_nxt = n; w_nxt = lmaddr;
        end
      end
      default: ;
    endcase
  end

  assign word_a = lwaddr[RAM_ADDR_BITS-1:1];
  generate
    if (BW == 1) begin : g_bank
      assign ram_a = {rbank_r, word_a};
    end else begin : g_nobank
      assign ram_a = {1'b0, word_a};
    end
  endgenerate

  gsu_byte_ram #(.AW(AW)) u_ram (
    .clk       (clk),
    .en        (s1_go && (load_nxt || store_nxt)),
    .we        (store_nxt),
    .waddr     (ram_a),
    .wdata_even(swap_nxt ? w_nxt[15:8] : w_nxt[7:0]),
    .wdata_odd (swap_nxt ? w_nxt[7:0] : w_nxt[15:8]),
    .rdata_even(ram_re),
    .rdata_odd (ram_ro)
  );

  // stage 1 -> stage 2; bank/address state updates at issue (in order)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0; rbank_r <= 1'b0; rombank_r <= 7'd0; ramaddr_r <= 16'd0;
    end else begin
      if (s1_go) begin
        s2_valid_r <= 1'b1;
        rbank_r <= rbank_nxt; rombank_r <= rombank_nxt;
        if (addr_upd) ramaddr_r <= lwaddr;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // carry the address and bank view with the beat; the output register
  // may still be holding an older result
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_load_r <= load_nxt; s2_swap_r <= swap_nxt; s2_wr_r <= wr_nxt;
      s2_widx_r <= widx_nxt; s2_wval_r <= w_nxt; s2_setzs_r <= setzs_nxt;
      s2_hib_r <= hib_nxt; s2_setov_r <= setov_nxt; s2_nsrc_r <= nsrc_nxt;
      s2_clr_r <= clr_nxt; s2_used_r <= used_nxt;
      s2_addr_r <= addr_upd ? lwaddr : ramaddr_r;
      s2_rbank_r <= rbank_nxt; s2_rombank_r <= rombank_nxt;
    end
  end

  // stage 2: write back and load the output register
  logic zf_nxt, sf_nxt, of_nxt;
  always_comb begin
    zf_nxt = zf_r; sf_nxt = sf_r; of_nxt = of_r;
    if (s2_hib_r) begin
      zf_nxt = (s2_val[7:0] == 8'd0); sf_nxt = s2_val[7];
    end else if (s2_setzs_r) begin
      zf_nxt = (s2_val == 16'd0); sf_nxt = s2_val[15];
    end
    if (s2_setov_r) of_nxt = s2_val[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) rf_r[i] <= 16'd0;
      zf_r <= 1'b0; sf_r <= 1'b0; of_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (s2_go) begin
        if (s2_wr_r) rf_r[s2_widx_r] <= s2_val;
        zf_r <= zf_nxt; sf_r <= sf_nxt; of_r <= of_nxt;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_wrote_register <= s2_wr_r;
      out_written_index  <= s2_wr_r ? s2_widx_r : 4'd0;
      out_written_value  <= s2_wr_r ? s2_val : 16'd0;
      out_zero_flag <= zf_nxt; out_sign_flag <= sf_nxt; out_overflow_flag <= of_nxt;
      out_last_ram_address <= s2_addr_r;
      out_ram_bank_out <= s2_rbank_r; out_rom_bank_out <= s2_rombank_r;
      out_next_src_sel <= s2_nsrc_r; out_prefix_cleared <= s2_clr_r;
      out_operand_bytes_used <= s2_used_r;
    end
  end

  // hold the result while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_written_value)
      && $stable(out_last_ram_address))
    else $error("result changed under stall");
  // no acceptance while stage 2 is blocked
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("accept with blocked stage 2");
  // every accepted beat reaches stage 2
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s2_valid_r)
    else $error("beat lost");
endmodule
`default_nettype wire
